// File: rtl/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bba_pkg
// types and codes shared by the buddy block allocator
// ---------------------------------------------------------------------------
package bba_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ABSENT = 2'd0;
  localparam logic [1:0] ST_FREE   = 2'd1;
  localparam logic [1:0] ST_USED   = 2'd2;
  localparam logic [1:0] ST_SPLIT  = 2'd3;

  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_NO_SPACE = 2'd1;
  localparam logic [1:0] RES_BAD_OFF  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [20:0] request_size;
    logic [19:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] granted_offset;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/buddy_block_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// buddy_block_allocator_core
// binary buddy allocator with the node tree held in one node memory
// ---------------------------------------------------------------------------
// channel   ports                 handshake
// input     in_item               start & !busy accepts a transaction
// result    out_result            out_valid strobe, one cycle, no stall
//
// the request is prepared first, then every node visit is a memory read
// followed by an evaluate; an allocate adds two node writes per split level and one
// grant write, a free adds a buddy read, evaluate and write back per merged level
// and a closing buddy read and leaf write. the result strobe
// follows on the cycle after the last state.
// after reset a clearing pass sweeps the node
// memory; busy stays high meanwhile. the receiver cannot stall results.
// ---------------------------------------------------------------------------
module buddy_block_allocator_core #(
  parameter int TREE_LEVELS    = 10,
  parameter int MIN_BLOCK_LOG2 = 10
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  bba_pkg::in_item_t     in_item,
  output logic                  out_valid,
  output bba_pkg::out_item_t    out_result
);
  import bba_pkg::*;

  localparam int NW      = TREE_LEVELS + 1;          // node index bits
  localparam int DW      = $clog2(TREE_LEVELS + 1);  // depth bits
  localparam int TOT_LOG2 = TREE_LEVELS + MIN_BLOCK_LOG2;

  typedef enum logic [11:0] {
    S_CLR  = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_PREP = 12'b000000000100,
    S_ARD  = 12'b000000001000,
    S_AEV  = 12'b000000010000,
    S_SPA  = 12'b000000100000,
    S_SPB  = 12'b000001000000,
    S_AUSE = 12'b000010000000,
    S_FRD  = 12'b000100000000,
    S_FEV  = 12'b001000000000,
    S_MEV  = 12'b010000000000,
    S_MWB  = 12'b100000000000
  } state_t;

  // node memory, entry 0 unused
  logic [1:0] node_mem [2**NW];
  logic [1:0] rdata_r;
  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [NW-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= node_mem[mem_raddr];
  end

  state_t        state_r, state_nxt;
  logic [NW-1:0] node_r, node_nxt;     // also the clear counter
  logic [DW-1:0] dep_r, dep_nxt;
  logic [DW-1:0] tgt_r, tgt_nxt;
  logic          merge_r, merge_nxt;   // merge phase of a free
  in_item_t      item_r, item_nxt;
  logic          out_valid_nxt;
  out_item_t     out_r, out_nxt;

  // request rounding: smallest k with size <= minblock << k
  logic          fit;
  logic [DW-1:0] kk;
  logic [63:0]   off_ext;
  logic [63:0]   low_mask;
  logic          choose_right;
  // skip to the next node in depth-first order
  logic [NW:0]   succ;
  int            strip;
  logic [NW-1:0] next_node;
  logic [63:0]   grant64;

  always_comb begin
    fit = 1'b0;
    kk  = '0;
    for (int k = TREE_LEVELS; k >= 0; k--) begin
      if ({43'd0, item_r.request_size} <= (64'd1 << (MIN_BLOCK_LOG2 + k))) begin
        fit = 1'b1;
        kk  = DW'(k);
      end
    end
  end

  assign off_ext      = {44'd0, item_r.block_offset};
  assign low_mask     = (64'd1 << (TOT_LOG2 - int'(dep_r))) - 64'd1;
  assign choose_right = off_ext[TOT_LOG2 - 1 - int'(dep_r)];

  always_comb begin
    succ  = {1'b0, node_r} + {{NW{1'b0}}, 1'b1};
    strip = 0;
    for (int j = NW; j >= 0; j--) begin
      if (succ[j]) begin
        strip = j;
      end
    end
    next_node = NW'(succ >> strip);
  end

  // byte offset of the node at the current depth
  assign grant64 = ({{(64-NW){1'b0}}, node_r} & ~(64'd1 << dep_r))
                   << (TOT_LOG2 - int'(dep_r));

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    node_nxt      = node_r;
    dep_nxt       = dep_r;
    tgt_nxt       = tgt_r;
    merge_nxt     = merge_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = node_r;
    mem_wdata     = ST_ABSENT;
    mem_raddr     = node_r;
    case (state_r)
      S_CLR: begin
        // sweep every entry; the root comes up as a free leaf
        mem_we    = 1'b1;
        mem_wdata = (node_r == NW'(1)) ? ST_FREE : ST_ABSENT;
        node_nxt  = node_r + NW'(1);
        if (node_r == {NW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        node_nxt  = NW'(1);
        dep_nxt   = '0;
        merge_nxt = 1'b0;
        if (item_r.operation == OP_ALLOC) begin
          if (!fit) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: RES_NO_SPACE, granted_offset: '0};
            state_nxt     = S_IDLE;
          end else begin
            tgt_nxt   = DW'(TREE_LEVELS) - kk;
            state_nxt = S_ARD;
          end
        end else begin
          if ((off_ext >> TOT_LOG2) != 64'd0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: RES_BAD_OFF, granted_offset: '0};
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_ARD: begin
        state_nxt = S_AEV;
      end
      S_AEV: begin
        if (rdata_r == ST_FREE && dep_r <= tgt_r) begin
          state_nxt = (dep_r == tgt_r) ? S_AUSE : S_SPA;
        end else if (rdata_r == ST_SPLIT && dep_r < tgt_r) begin
          node_nxt  = {node_r[NW-2:0], 1'b0};
          dep_nxt   = dep_r + DW'(1);
          state_nxt = S_ARD;
        end else if (strip > int'(dep_r)) begin
          // searched the whole tree
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: RES_NO_SPACE, granted_offset: '0};
          state_nxt     = S_IDLE;
        end else begin
          node_nxt  = next_node;
          dep_nxt   = dep_r - DW'(strip);
          state_nxt = S_ARD;
        end
      end
      S_SPA: begin
        mem_we    = 1'b1;
        mem_wdata = ST_SPLIT;
        state_nxt = S_SPB;
      end
      S_SPB: begin
        // right half becomes free, continue down the left half
        mem_we    = 1'b1;
        mem_waddr = {node_r[NW-2:0], 1'b1};
        mem_wdata = ST_FREE;
        node_nxt  = {node_r[NW-2:0], 1'b0};
        dep_nxt   = dep_r + DW'(1);
        state_nxt = ((dep_r + DW'(1)) == tgt_r) ? S_AUSE : S_SPA;
      end
      S_AUSE: begin
        mem_we        = 1'b1;
        mem_wdata     = ST_USED;
        out_valid_nxt = 1'b1;
        out_nxt       = '{status: RES_OK, granted_offset: grant64[19:0]};
        state_nxt     = S_IDLE;
      end
      S_FRD: begin
        mem_raddr = merge_r ? (node_r ^ NW'(1)) : node_r;
        state_nxt = merge_r ? S_MEV : S_FEV;
      end
      S_FEV: begin
        if (rdata_r == ST_SPLIT && int'(dep_r) < TREE_LEVELS) begin
          node_nxt  = {node_r[NW-2:0], choose_right};
          dep_nxt   = dep_r + DW'(1);
          state_nxt = S_FRD;
        end else if (rdata_r == ST_USED && (off_ext & low_mask) == 64'd0) begin
          if (node_r == NW'(1)) begin
            mem_we        = 1'b1;
            mem_wdata     = ST_FREE;
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: RES_OK, granted_offset: '0};
            state_nxt     = S_IDLE;
          end else begin
            merge_nxt = 1'b1;
            state_nxt = S_FRD;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: RES_BAD_OFF, granted_offset: '0};
          state_nxt     = S_IDLE;
        end
      end
      S_MEV: begin
        if (rdata_r == ST_FREE && node_r != NW'(1)) begin
          // buddy free too: drop the buddy, then this node
          mem_we    = 1'b1;
          mem_waddr = node_r ^ NW'(1);
          state_nxt = S_MWB;
        end else begin
          // no more merging (or root reached): this node becomes a free leaf
          mem_we        = 1'b1;
          mem_wdata     = ST_FREE;
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: RES_OK, granted_offset: '0};
          state_nxt     = S_IDLE;
        end
      end
      S_MWB: begin
        mem_we    = 1'b1;
        node_nxt  = node_r >> 1;
        state_nxt = S_FRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      node_r     <= '0;
      out_valid  <= 1'b0;
      merge_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      node_r     <= node_nxt;
      out_valid  <= out_valid_nxt;
      merge_r    <= merge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dep_r      <= dep_nxt;
    tgt_r      <= tgt_nxt;
    item_r     <= item_nxt;
    out_r      <= out_nxt;
  end

  assign out_result = out_r;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// checks the buddy block allocator against a behavioral tree model, with
// directed corner cases, allocate/free mixes and random sender gaps
// ---------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  localparam int LEVELS    = 10;
  localparam int MIN_LOG2  = 10;
  localparam int NODES     = 2 << LEVELS;
  localparam longint MEM_BYTES = longint'(1) << (MIN_LOG2 + LEVELS);
  localparam int CYCLE_LIMIT = 20000000;
  localparam int RANDOM_ITEMS = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_result;

  buddy_block_allocator_core #(
    .TREE_LEVELS(LEVELS),
    .MIN_BLOCK_LOG2(MIN_LOG2)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_result(out_result)
  );

  always #10 clk = ~clk;

  // predictor state: node tree in heap order
  logic [1:0] tree_state [NODES];
  out_item_t expected_results [$];
  in_item_t pending_items [$];
  int pause_marks [$];           // item counts before which the sender drains
  int failures = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int gap_left = 0;
  // queue for held offsets, declared but never filled
  logic [19:0] held_offsets [$];

  // depth-first, left-first search for a free leaf at depth target
  function automatic bit grant_search(int idx, int depth, longint base, int target,
                                      ref longint got);
    longint half;
    if (idx >= NODES || depth > LEVELS) return 0;
    half = MEM_BYTES >> (depth + 1);
    if (tree_state[idx] == ST_FREE) begin
      if (depth > target) return 0;
      if (depth == target) begin
        tree_state[idx] = ST_USED;
        got = base;
        return 1;
      end
      if (depth >= LEVELS) return 0;
      tree_state[idx] = ST_SPLIT;
      tree_state[2*idx] = ST_FREE;
      tree_state[2*idx+1] = ST_FREE;
      return grant_search(2*idx, depth + 1, base, target, got);
    end
    if (tree_state[idx] == ST_SPLIT && depth < LEVELS) begin
      if (grant_search(2*idx, depth + 1, base, target, got)) return 1;
      return grant_search(2*idx+1, depth + 1, base + half, target, got);
    end
    return 0;
  endfunction

  function automatic out_item_t predict_allocation(in_item_t item);
    out_item_t res;
    longint got;
    longint want;
    int k;
    int idx;
    int depth;
    longint base;
    longint half;
    res = '0;
    got = 0;
    k = 0;
    if (item.operation == OP_ALLOC) begin
      want = longint'(item.request_size);
      while (k <= LEVELS && ((longint'(1) << (MIN_LOG2 + k)) < want)) k++;
      if (k > LEVELS || !grant_search(1, 0, 0, LEVELS - k, got)) begin
        res.status = RES_NO_SPACE;
      end else begin
        res.status = RES_OK;
        res.granted_offset = got[19:0];
      end
      return res;
    end
    idx = 1;
    depth = 0;
    base = 0;
    res.status = RES_BAD_OFF;
    if (longint'(item.block_offset) >= MEM_BYTES) return res;
    while (tree_state[idx] == ST_SPLIT && depth < LEVELS) begin
      half = MEM_BYTES >> (depth + 1);
      if (longint'(item.block_offset) >= base + half) begin
        base += half;
        idx = 2*idx + 1;
      end else begin
        idx = 2*idx;
      end
      depth++;
    end
    if (tree_state[idx] != ST_USED || base != longint'(item.block_offset)) return res;
    tree_state[idx] = ST_FREE;
    // merge free buddies upward
    while (idx > 1 && tree_state[(idx>>1)*2] == ST_FREE
           && tree_state[(idx>>1)*2+1] == ST_FREE) begin
      tree_state[(idx>>1)*2] = ST_ABSENT;
      tree_state[(idx>>1)*2+1] = ST_ABSENT;
      idx = idx >> 1;
      tree_state[idx] = ST_FREE;
    end
    res.status = RES_OK;
    return res;
  endfunction

  function automatic in_item_t make_item(logic op, logic [20:0] sz, logic [19:0] off);
    in_item_t it;
    it.operation = op;
    it.request_size = sz;
    it.block_offset = off;
    return it;
  endfunction

  // size mostly within the tree, biased toward small blocks
  function automatic logic [20:0] random_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 21'($urandom_range(0, 8192));
    if (pick < 85) return 21'($urandom_range(0, 131072));
    if (pick < 95) return 21'($urandom_range(0, 1048576));
    return 21'($urandom);
  endfunction

  initial begin
    int i;
    int pick;
    logic [19:0] off;
    for (i = 0; i < NODES; i++) tree_state[i] = ST_ABSENT;
    tree_state[1] = ST_FREE;
    // directed: zero size, minimum, whole memory, too large, frees
    pending_items.push_back(make_item(OP_ALLOC, 21'd0, 20'hFFFFF));
    pending_items.push_back(make_item(OP_ALLOC, 21'd1, 20'd0));
    pending_items.push_back(make_item(OP_ALLOC, 21'd1024, 20'd0));
    pending_items.push_back(make_item(OP_ALLOC, 21'd1025, 20'd0));
    pending_items.push_back(make_item(OP_ALLOC, 21'd1048577, 20'd0));
    pending_items.push_back(make_item(OP_ALLOC, 21'h1FFFFF, 20'd0));
    pending_items.push_back(make_item(OP_ALLOC, 21'd1048576, 20'd0));
    pending_items.push_back(make_item(OP_FREE, 21'h1FFFFF, 20'd512));
    pending_items.push_back(make_item(OP_FREE, 21'd0, 20'hFFFFF));
    pending_items.push_back(make_item(OP_FREE, 21'd0, 20'd1024));
    pending_items.push_back(make_item(OP_FREE, 21'd0, 20'd0));
    pending_items.push_back(make_item(OP_FREE, 21'd0, 20'd0));
    pending_items.push_back(make_item(OP_FREE, 21'd0, 20'd2048));
    pending_items.push_back(make_item(OP_FREE, 21'd0, 20'd0));
    pending_items.push_back(make_item(OP_FREE, 21'd0, 20'd0));
    pending_items.push_back(make_item(OP_ALLOC, 21'd1048576, 20'd0));
    pending_items.push_back(make_item(OP_ALLOC, 21'd1, 20'd0));
    pending_items.push_back(make_item(OP_FREE, 21'd0, 20'd0));
    pending_items.push_back(make_item(OP_FREE, 21'd0, 20'd0));
    pause_marks.push_back(pending_items.size());
    // random: allocates, frees at aligned offsets, and raw noise items
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (i == RANDOM_ITEMS / 2) pause_marks.push_back(pending_items.size());
      if (pick < 50) begin
        pending_items.push_back(make_item(OP_ALLOC, random_size(), 20'($urandom)));
      end else if (pick < 85) begin
        // aligned offsets hit real blocks often
        off = 20'($urandom_range(0, 1023)) << $urandom_range(10, 19);
        off = off & (20'hFFFFF << 10);
        pending_items.push_back(make_item(OP_FREE, 21'($urandom), off));
      end else begin
        pending_items.push_back(make_item(1'($urandom), 21'($urandom), 20'($urandom)));
      end
    end
  end

  // driver: start held until accepted, gap drawn per transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(predict_allocation(in_item));
        items_sent <= items_sent + 1;
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
        start <= 1'b0;
      end else if (!start || busy) begin
        if (!start) begin
          if (gap_left > 0) begin
            gap_left <= gap_left - 1;
          end else if (pending_items.size() > 0
                       && !(pause_marks.size() > 0 && pause_marks[0] == items_sent
                            && expected_results.size() > 0)) begin
            if (pause_marks.size() > 0 && pause_marks[0] == items_sent)
              void'(pause_marks.pop_front());
            in_item <= pending_items.pop_front();
            start <= 1'b1;
          end
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d offset=%0d",
                 $time, out_result.status, out_result.granted_offset);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_result.status);
          failures++;
        end
        if (out_result.granted_offset !== want.granted_offset) begin
          $display("%0t: granted_offset expected %0d actual %0d",
                   $time, want.granted_offset, out_result.granted_offset);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // wait for every item to be sent and answered
    wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: buddy_block_allocator_core.f
rtl/bba_pkg.sv
rtl/buddy_block_allocator_core.sv
tb/sv/testbench.sv
